/* hdl/dtp_pkg.sv */
// Package: pixel format codes and shared constants for the double-to-pixel encoder.
package dtp_pkg;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_F32 = 3'd3,
    FMT_F64 = 3'd4
  } pixel_format_e;

  localparam int unsigned ExpBias = 1023;

endpackage

/* hdl/double_to_pixel_saturating_encoder_unit.sv */
// Top level: converts one IEEE-754 double per beat into the configured pixel format.
// One sample is taken per clock; busy is tied low, so start may be held high
// every cycle. The result appears on the cycle after acceptance, marked by
// result_valid_o, and stays for exactly one cycle; the receiver cannot stall,
// so a result must be captured when the strobe is high. A single register
// lies between the input and the result ports. The format register is written
// through cfg_valid_i/cfg_ready_o; the user must write it only while idle, as the block does not enforce this.
module double_to_pixel_saturating_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] sample_bits_i,
  input  logic        run_end_in_i,
  output logic        result_valid_o,
  output logic [63:0] raw_word_o,
  output logic [3:0]  byte_count_o,
  output logic        run_end_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);

  logic [2:0]  fmt_q;
  logic        vld_q;
  logic [63:0] word_q, word_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        end_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // field split
  logic        sgn;
  logic [10:0] ef;
  logic [51:0] frac;
  logic [52:0] sig;
  assign sgn  = sample_bits_i[63];
  assign ef   = sample_bits_i[62:52];
  assign frac = sample_bits_i[51:0];
  assign sig  = {1'b1, frac};

  // integer path: magnitude for exponents 0..39, saturate beyond
  logic        is_nan, is_inf;
  logic [39:0] mag;
  logic        big;
  logic [11:0] e_s;
  assign is_nan = (ef == 11'h7FF) && (frac != '0);
  assign is_inf = (ef == 11'h7FF) && (frac == '0);
  assign e_s    = {1'b0, ef} - 12'(dtp_pkg::ExpBias);
  assign big    = is_inf || (!e_s[11] && (e_s >= 12'd40));
  always_comb begin
    if (e_s[11] || big) mag = '0;
    else mag = 40'(sig >> (6'd52 - e_s[5:0]));
  end

  function automatic logic [31:0] sat_int(input logic nan, input logic bg,
                                          input logic neg, input logic [39:0] m,
                                          input logic [31:0] lo_mag,
                                          input logic [31:0] hi);
    logic [31:0] r;
    if (nan) r = '0;
    else if (neg) begin
      if (bg || m > {8'd0, lo_mag}) r = 32'(-lo_mag);
      else r = 32'(-m[31:0]);
    end else begin
      if (bg || m > {8'd0, hi}) r = hi;
      else r = m[31:0];
    end
    return r;
  endfunction

  // clamped integers per format
  logic [31:0] int_u8, int_s16, int_s32;
  assign int_u8  = sat_int(is_nan, big, sgn, mag, 32'd0, 32'd255);
  assign int_s16 = sat_int(is_nan, big, sgn, mag, 32'd32768, 32'd32767);
  assign int_s32 = sat_int(is_nan, big, sgn, mag, 32'h8000_0000, 32'h7FFF_FFFF);

  // single float path
  logic [31:0] f32;
  logic [12:0] fe;      // signed biased single exponent
  logic [12:0] sub_sh;  // subnormal shift, 30 - fe
  logic [6:0]  shamt;
  logic [52:0] shq, rem_mask;
  logic [53:0] halfv;
  logic [52:0] rem;
  logic [24:0] qr;      // one extra bit for the rounding carry into the exponent
  logic        rup;
  assign fe     = {2'b0, ef} - 13'd896;
  assign sub_sh = 13'd30 - fe;
  always_comb begin
    // normal: shift 29; subnormal: 30 - fe, clamped at 55 (flushes to zero)
    if (!fe[12] && fe != '0) shamt = 7'd29;
    else if (sub_sh >= 13'd55) shamt = 7'd55;
    else shamt = 7'(sub_sh);
    shq      = sig >> shamt[5:0];
    rem_mask = ~(53'h1F_FFFF_FFFF_FFFF << shamt[5:0]);
    rem      = sig & rem_mask;
    halfv    = 54'd1 << (shamt[5:0] - 6'd1);
    rup      = ({1'b0, rem} > halfv) || (({1'b0, rem} == halfv) && shq[0]);
    qr       = shq[24:0] + 25'(rup);
    if (ef == 11'h7FF) begin
      if (frac == '0) f32 = {sgn, 31'h7F80_0000};
      else f32 = {sgn, 9'h1FF, frac[50:29]};
    end else if (ef == '0) f32 = {sgn, 31'd0};
    else if (!fe[12] && fe >= 13'd255) f32 = {sgn, 31'h7F80_0000};
    else if (!fe[12] && fe != '0)
      f32 = {sgn, {(fe[7:0] - 8'd1), 23'd0} + {6'd0, qr}};
    else if (shamt >= 7'd55) f32 = {sgn, 31'd0};
    else f32 = {sgn, 6'd0, qr};
  end

  // format select
  always_comb begin
    case (fmt_q)
      dtp_pkg::FMT_U8: begin
        word_d = {56'd0, int_u8[7:0]};
        cnt_d  = 4'd1;
      end
      dtp_pkg::FMT_S16: begin
        word_d = {48'd0, int_s16[15:0]};
        cnt_d  = 4'd2;
      end
      dtp_pkg::FMT_S32: begin
        word_d = {32'd0, int_s32};
        cnt_d  = 4'd4;
      end
      dtp_pkg::FMT_F32: begin
        word_d = {32'd0, f32};
        cnt_d  = 4'd4;
      end
      default: begin
        word_d = sample_bits_i;
        cnt_d  = 4'd8;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= dtp_pkg::FMT_U8;
      vld_q <= 1'b0;
    end else begin
      vld_q <= start;
      if (cfg_valid_i && cfg_ready_o) fmt_q <= cfg_data_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cnt_q  <= cnt_d;
    end_q  <= run_end_in_i;
  end

  assign result_valid_o = vld_q;
  assign raw_word_o     = word_q;
  assign byte_count_o   = cnt_q;
  assign run_end_out_o  = end_q;

  // each accepted beat yields exactly one strobe on the next cycle
  a_one_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o) else $error("missing result");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |=> !result_valid_o) else $error("spurious result");
  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (byte_count_o == 4'd1 || byte_count_o == 4'd2 ||
                        byte_count_o == 4'd4 || byte_count_o == 4'd8))
    else $error("bad byte count");
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && byte_count_o == 4'd4) |-> (raw_word_o[63:32] == '0))
    else $error("upper bytes not zero");

endmodule

/* test/testbench.sv */
// Testbench for the double-to-pixel encoder: directed and random samples, scoreboard check.
`timescale 1ns / 1ps

module testbench;

  // Expected encoded pixel for one accepted sample
  typedef struct packed {
    logic [63:0] raw_word;
    logic [3:0]  byte_count;
    logic        run_end;
  } pixel_t;

  // Scoreboard: encodes samples at the current format and matches result beats
  class pixel_scoreboard;
    pixel_t      pending[$];
    logic [2:0]  fmt;
    int unsigned mismatches;

    function new();
      fmt = dtp_pkg::FMT_U8;
      mismatches = 0;
    endfunction

    // Round right shift, nearest-even
    function logic [63:0] shift_rne(logic [63:0] sig, int unsigned sh);
      logic [63:0] q, rem, half;
      if (sh == 0) return sig;
      if (sh >= 63) return 64'd0;
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
    endfunction

    function logic [31:0] encode_single(logic [63:0] b);
      logic [31:0] sgn;
      int ef, fe;
      logic [51:0] frac;
      logic [63:0] sig, q;
      sgn = {b[63], 31'd0};
      ef = b[62:52];
      frac = b[51:0];
      if (ef == 2047) begin
        if (frac == 0) return sgn | 32'h7F80_0000;
        return sgn | 32'h7FC0_0000 | {10'd0, frac[50:29]};
      end
      if (ef == 0) return sgn;
      sig = {12'd1, frac};
      fe = ef - 1023 + 127;
      if (fe >= 255) return sgn | 32'h7F80_0000;
      if (fe >= 1) begin
        q = shift_rne(sig, 29);
        q = (64'(fe - 1) << 23) + q;
        return sgn | q[31:0];
      end
      if (30 - fe >= 55) return sgn;
      q = shift_rne(sig, 30 - fe);
      return sgn | q[31:0];
    endfunction

    // Saturating truncation to an integer range
    function logic [63:0] encode_int(logic [63:0] b, longint lo, longint hi);
      int ef, e;
      logic [63:0] mag;
      longint v;
      ef = b[62:52];
      if (ef == 2047 && b[51:0] != 0) return 64'd0;
      e = ef - 1023;
      if (ef == 2047 || e >= 40) return b[63] ? lo : hi;
      mag = (e < 0) ? 64'd0 : ({12'd1, b[51:0]} >> (52 - e));
      if (b[63]) v = (mag > 64'(-lo)) ? lo : -longint'(mag);
      else v = (mag > 64'(hi)) ? hi : longint'(mag);
      return v;
    endfunction

    function void note_sample(logic [63:0] b, logic run_end);
      pixel_t p;
      p.run_end = run_end;
      case (fmt)
        dtp_pkg::FMT_U8: begin
          p.raw_word = encode_int(b, 0, 255) & 64'hFF;
          p.byte_count = 4'd1;
        end
        dtp_pkg::FMT_S16: begin
          p.raw_word = encode_int(b, -32768, 32767) & 64'hFFFF;
          p.byte_count = 4'd2;
        end
        dtp_pkg::FMT_S32: begin
          p.raw_word = encode_int(b, -64'sd2147483648, 2147483647) & 64'hFFFF_FFFF;
          p.byte_count = 4'd4;
        end
        dtp_pkg::FMT_F32: begin
          p.raw_word = {32'd0, encode_single(b)};
          p.byte_count = 4'd4;
        end
        default: begin
          p.raw_word = b;
          p.byte_count = 4'd8;
        end
      endcase
      pending = {pending, p};
    endfunction

    function void check_result(pixel_t act);
      pixel_t exp_p;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", act);
        return;
      end
      exp_p = pending.pop_front();
      if (act !== exp_p) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp word %h cnt %0d end %b, got word %h cnt %0d end %b",
                   exp_p.raw_word, exp_p.byte_count, exp_p.run_end,
                   act.raw_word, act.byte_count, act.run_end);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [63:0] sample_bits_i = '0;
  logic        run_end_in_i = 0;
  logic        result_valid_o;
  logic [63:0] raw_word_o;
  logic [3:0]  byte_count_o;
  logic        run_end_out_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i = '0;

  pixel_scoreboard sb = new();
  int unsigned     stall_cycles = 0;
  bit              no_gaps = 0;

  double_to_pixel_saturating_encoder_unit u_dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Monitor: sample handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result({raw_word_o, byte_count_o, run_end_out_o});
      if (start && !busy) sb.note_sample(sample_bits_i, run_end_in_i);
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles > 2000) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Send one sample beat; start stays high when the next beat follows at once
  task automatic send_sample(logic [63:0] b, logic run_end);
    while (!no_gaps && $urandom_range(99) < 8) begin
      start <= 0;
      @(negedge clk_i);
    end
    start <= 1;
    sample_bits_i <= b;
    run_end_in_i <= run_end;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Format write while idle
  task automatic set_format(logic [2:0] f);
    drain();
    cfg_valid_i <= 1;
    cfg_data_i <= f;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.fmt = f;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Random sample biased toward interesting exponents
  function automatic logic [63:0] rand_sample();
    logic [63:0] b;
    int unsigned k;
    b = {$urandom, $urandom};
    k = $urandom_range(9);
    case (k)
      0, 1, 2: b[62:52] = 11'(1023 + $urandom_range(0, 16) - 2);
      3:       b[62:52] = 11'(1023 + $urandom_range(17, 45));
      4, 5:    b[62:52] = 11'(1023 - 127 + $urandom_range(0, 256) - 26);
      6:       b[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
      7:       b[62:52] = 11'(1023 - 127 + $urandom_range(0, 60) - 40);
      default: ;
    endcase
    if (k == 8) b[28:0] = $urandom_range(1) ? 29'h1000_0000 : 29'h0;
    return b;
  endfunction

  logic [63:0] directed [0:19] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
    64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFF7_FFFF_FFFF_FFFF,
    64'h406F_E000_0000_0000, 64'h4070_0000_0000_0000, 64'hC0E0_0000_0000_0000,
    64'hC0E0_0020_0000_0000, 64'h41DF_FFFF_FFC0_0000, 64'hC1E0_0000_0000_0000,
    64'h3FEF_FFFF_FFFF_FFFF, 64'hBFF8_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF,
    64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0001, 64'h47EF_FFFF_F000_0000,
    64'h3FF0_0000_1000_0000, 64'hFFFF_FFFF_FFFF_FFFF
  };

  initial begin
    int unsigned fmts [0:7] = '{0, 1, 2, 3, 4, 5, 6, 7};
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Directed: every format over the edge samples (reset format first)
    foreach (fmts[f]) begin
      if (f != 0) set_format(3'(fmts[f]));
      for (int i = 0; i < 20; i++) send_sample(directed[i], i[0]);
    end
    // Random phases across formats, one with back-to-back beats only
    for (int ph = 0; ph < 11; ph++) begin
      set_format(ph < 2 ? ((ph == 0) ? dtp_pkg::FMT_U8 : 3'd7) : 3'($urandom_range(7)));
      no_gaps = (ph == 5);
      for (int i = 0; i < 50; i++) send_sample(rand_sample(), 1'($urandom_range(1)));
    end
    no_gaps = 0;
    drain();
    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
